// File: hw/rtl/lowess_pkg.sv
// ----------------------------------------------------------------------------
// lowess_pkg
// Shared widths, constants and divider handshake types for the local linear
// smoother.
// ----------------------------------------------------------------------------
package lowess_pkg;

    localparam int MAX_PTS = 64;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int DATA_W  = 24;
    localparam int SPAN_W  = 17;

    localparam logic [SPAN_W-1:0] ONE_Q16 = 17'd65536;

    localparam int MUL_W  = 35;
    localparam int PROD_W = 2 * MUL_W;

    localparam int DIV_DVD_W = 54;
    localparam int DIV_DVS_W = 32;
    localparam int DIV_CNT_W = 6;

    localparam int SAT_POS_MAG = 2 ** (DATA_W - 1) - 1;
    localparam int SAT_NEG_MAG = 2 ** (DATA_W - 1);

    localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// File: hw/rtl/lowess_div.sv
// ----------------------------------------------------------------------------
// lowess_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lowess_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lowess_pkg::t_div_req  i_req,
    output lowess_pkg::t_div_rsp  o_rsp
);

    localparam int DW = lowess_pkg::DIV_DVD_W;
    localparam int VW = lowess_pkg::DIV_DVS_W;
    localparam int CW = lowess_pkg::DIV_CNT_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;

    logic [VW:0]   sh;
    logic [VW:0]   diff;
    logic          qbit;
    logic [VW-1:0] rem_nx;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        sh     = {r_rem, r_q[DW-1]};
        diff   = sh - {1'b0, r_dvs};
        qbit   = (sh >= {1'b0, r_dvs});
        rem_nx = qbit ? diff[VW-1:0] : sh[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_cnt <= CW'(DW - 1);
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], qbit};
            r_rem <= rem_nx;
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

endmodule

// File: hw/rtl/lowess_local_linear_fit.sv
// ----------------------------------------------------------------------------
// lowess_local_linear_fit
// One-pass local linear scatter smoother with tricube weights.
// ----------------------------------------------------------------------------
// Points are loaded one beat at a time with start while busy is low, up to 64
// per set; further points are dropped, and a beat with i_last_point set closes
// the set and starts fitting. The block then stays busy while it stable-sorts
// the set by x, one compare at a time, and fits every point over its window
// of k sorted neighbors, scaling window points in the shared one-bit-per-cycle
// divider; the single shared multiplier does all products. Results then leave
// in load order, one beat at a time, each shown for exactly one cycle with
// o_strobe. The receiver cannot hold results off, so it must take every beat
// as it comes. The span register may be written only while busy is low.
// ----------------------------------------------------------------------------
module lowess_local_linear_fit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lowess_pkg::SPAN_W-1:0]        i_cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [lowess_pkg::DATA_W-1:0] i_x_value,
    input  logic signed [lowess_pkg::DATA_W-1:0] i_y_value,
    input  logic                                 i_last_point,
    output logic                                 o_strobe,
    output logic signed [lowess_pkg::DATA_W-1:0] o_fitted_value,
    output logic [lowess_pkg::IDX_W-1:0]         o_point_index,
    output logic                                 o_last_result
);

    localparam int DW  = lowess_pkg::DATA_W;
    localparam int IW  = lowess_pkg::IDX_W;
    localparam int CW  = lowess_pkg::CNT_W;
    localparam int MW  = lowess_pkg::MUL_W;
    localparam int PW  = lowess_pkg::PROD_W;
    localparam int QW  = lowess_pkg::DIV_DVD_W;
    localparam int VW  = lowess_pkg::DIV_DVS_W;
    localparam int NP  = lowess_pkg::MAX_PTS;

    // Sequencer states, one-hot.
    typedef enum logic [33:0] {
        S_IDLE = 34'b1 << 0,
        S_KMUL = 34'b1 << 1,
        S_KSET = 34'b1 << 2,
        S_RP   = 34'b1 << 3,
        S_RPD  = 34'b1 << 4,
        S_RQ   = 34'b1 << 5,
        S_RQD  = 34'b1 << 6,
        S_RW   = 34'b1 << 7,
        S_WRI  = 34'b1 << 8,
        S_WDI  = 34'b1 << 9,
        S_MRD  = 34'b1 << 10,
        S_MDAT = 34'b1 << 11,
        S_BRD  = 34'b1 << 12,
        S_BDAT = 34'b1 << 13,
        S_BDIV = 34'b1 << 14,
        S_BM1  = 34'b1 << 15,
        S_BM2  = 34'b1 << 16,
        S_BM3  = 34'b1 << 17,
        S_BM4  = 34'b1 << 18,
        S_BM5  = 34'b1 << 19,
        S_BWU  = 34'b1 << 20,
        S_BB   = 34'b1 << 21,
        S_BBU  = 34'b1 << 22,
        S_BWY  = 34'b1 << 23,
        S_BBY  = 34'b1 << 24,
        S_F0   = 34'b1 << 25,
        S_F1   = 34'b1 << 26,
        S_F2   = 34'b1 << 27,
        S_F3   = 34'b1 << 28,
        S_F4   = 34'b1 << 29,
        S_F5   = 34'b1 << 30,
        S_FDIV = 34'b1 << 31,
        S_ORD  = 34'b1 << 32,
        S_OLAT = 34'b1 << 33
    } t_state;

    // Control registers.
    t_state                         r_state, n_state;
    logic [CW-1:0]                  r_cnt;
    logic [CW-1:0]                  r_n;
    logic [lowess_pkg::SPAN_W-1:0]  r_span;
    logic                           r_ostb;

    // Point stores, loaded in arrival order.
    logic signed [DW-1:0] r_x_store [NP];
    logic signed [DW-1:0] r_y_store [NP];
    logic signed [DW-1:0] r_x_rd, r_y_rd;
    // Copies in sorted order, plus the load position of each sorted entry.
    logic signed [DW-1:0] r_xs_store [NP];
    logic signed [DW-1:0] r_ys_store [NP];
    logic [IW-1:0]        r_so_store [NP];
    logic signed [DW-1:0] r_xs_rd, r_ys_rd;
    logic [IW-1:0]        r_so_rd;
    // Fits, addressed by load position.
    logic signed [DW-1:0] r_fit_store [NP];
    logic signed [DW-1:0] r_fit_rd;

    // Sequencer counters and window registers.
    logic [CW-1:0]        r_k;
    logic [IW-1:0]        r_p, r_q, r_rank, r_i, r_s, r_j, r_oi, r_soi;
    logic signed [DW-1:0] r_xp, r_yp, r_xi, r_y;
    logic [DW-1:0]        r_maxd;
    logic                 r_dneg;
    logic [16:0]          r_ua, r_t, r_w;
    logic signed [17:0]   r_u, r_b;

    // Window sums.
    logic [23:0]          r_s0;
    logic signed [23:0]   r_s1, r_s2;
    logic signed [39:0]   r_s2acc;
    logic signed [47:0]   r_t0, r_t1;
    logic signed [30:0]   r_ysum;
    logic signed [55:0]   r_tmp;
    logic signed [31:0]   r_det;
    logic                 r_qneg;

    // Shared multiplier.
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] r_prod;

    // Output registers.
    logic signed [DW-1:0] r_ofit;
    logic [IW-1:0]        r_oidx;
    logic                 r_olast;

    lowess_pkg::t_div_req div_req;
    lowess_pkg::t_div_rsp div_rsp;

    // Combinational helpers.
    logic                 accept;
    logic                 room;
    logic                 x_we;
    logic [IW-1:0]        rk_addr, win_addr, ws_addr;
    logic [23:0]          ksum;
    logic [7:0]           kraw, kclamp;
    logic signed [7:0]    s_raw;
    logic [CW-1:0]        nk;
    logic [IW-1:0]        s_val;
    logic signed [DW:0]   d_val;
    logic [DW-1:0]        ad_val;
    logic [16:0]          t_val;
    logic signed [17:0]   ua_s, u_val, b_val;
    logic signed [23:0]   s2_val;
    logic signed [45:0]   det_diff;
    logic signed [55:0]   num_val;
    logic [30:0]          abs_ysum;
    logic [47:0]          abs_t0;
    logic [55:0]          abs_num;
    logic [31:0]          abs_det;
    logic [DW-1:0]        q_low;
    logic signed [DW-1:0] fit_sat;
    logic                 p_last, q_last, j_last, i_last, o_last;
    logic                 rank_hit;

    assign accept   = start && !busy;
    assign room     = (r_cnt < CW'(NP));
    assign x_we     = accept && room;
    assign busy     = (r_state != S_IDLE);

    assign p_last   = (CW'(r_p) + CW'(1) == r_n);
    assign q_last   = (CW'(r_q) + CW'(1) == r_n);
    assign i_last   = (CW'(r_i) + CW'(1) == r_n);
    assign o_last   = (CW'(r_oi) + CW'(1) == r_n);
    assign j_last   = (CW'(r_j) + CW'(1) == r_k);

    assign rk_addr  = (r_state == S_RP) ? r_p : r_q;
    assign ws_addr  = r_s + r_j;
    assign win_addr = (r_state == S_WRI) ? r_i : ws_addr;

    // Stable rank: strictly smaller x, or equal x loaded earlier.
    assign rank_hit = (r_x_rd < r_xp) || ((r_x_rd == r_xp) && (r_q < r_p));

    always_comb begin
        // k = ceil(span * n), clamped to two and then to n.
        ksum   = r_prod[23:0] + 24'd65535;
        kraw   = ksum[23:16];
        kclamp = (kraw < 8'd2) ? 8'd2 : kraw;
        if (kclamp > 8'(r_n)) begin
            kclamp = 8'(r_n);
        end

        // Window start, centered on i and pushed back inside the set.
        nk    = r_n - r_k;
        s_raw = $signed({2'b00, r_i}) - $signed({2'b00, r_k[CW-1:1]});
        if (s_raw < 8'sd0) begin
            s_val = '0;
        end else if (s_raw > $signed({1'b0, nk})) begin
            s_val = IW'(nk);
        end else begin
            s_val = IW'(s_raw);
        end

        d_val  = (DW + 1)'(r_xs_rd) - (DW + 1)'(r_xi);
        ad_val = d_val[DW] ? DW'(-d_val) : DW'(d_val);

        t_val  = lowess_pkg::ONE_Q16 - 17'(r_prod[47:32]);
        ua_s   = $signed({1'b0, r_ua});
        u_val  = r_dneg ? -ua_s : ua_s;
        b_val  = $signed(r_prod[33:16]);
        s2_val = $signed(r_s2acc[39:16]);

        det_diff = r_tmp[45:0] - r_prod[45:0];
        num_val  = r_tmp - r_prod[55:0];

        abs_ysum = r_ysum[30] ? 31'(-r_ysum) : 31'(r_ysum);
        abs_t0   = r_t0[47] ? 48'(-r_t0) : 48'(r_t0);
        abs_num  = num_val[55] ? 56'(-num_val) : 56'(num_val);
        abs_det  = r_det[31] ? 32'(-r_det) : 32'(r_det);

        // Truncated quotient back to signed, saturated to the data range.
        q_low = div_rsp.quotient[DW-1:0];
        if (!r_qneg) begin
            fit_sat = (div_rsp.quotient > QW'(lowess_pkg::SAT_POS_MAG))
                    ? lowess_pkg::SAT_MAX : $signed(q_low);
        end else begin
            fit_sat = (div_rsp.quotient > QW'(lowess_pkg::SAT_NEG_MAG))
                    ? lowess_pkg::SAT_MIN : $signed(-q_low);
        end
    end

    // Operand selection for the shared multiplier and the divider.
    always_comb begin
        mul_a            = '0;
        mul_b            = '0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (r_state)
            S_KMUL: begin
                mul_a = MW'(r_span);
                mul_b = MW'(r_n);
            end
            S_BDAT: begin
                div_req.start    = (r_maxd != '0);
                div_req.dividend = QW'({ad_val, 16'd0});
                div_req.divisor  = VW'(r_maxd);
            end
            S_BM1: begin
                mul_a = MW'(r_ua);
                mul_b = MW'(r_ua);
            end
            S_BM2: begin
                mul_a = {1'b0, r_prod[33:0]};
                mul_b = MW'(r_ua);
            end
            S_BM3: begin
                mul_a = MW'(t_val);
                mul_b = MW'(t_val);
            end
            S_BM4: begin
                mul_a = {1'b0, r_prod[33:0]};
                mul_b = MW'(r_t);
            end
            S_BWU: begin
                mul_a = MW'(r_w);
                mul_b = MW'(u_val);
            end
            S_BB: begin
                mul_a = MW'(b_val);
                mul_b = MW'(r_u);
            end
            S_BBU: begin
                mul_a = MW'(r_w);
                mul_b = MW'(r_y);
            end
            S_BWY: begin
                mul_a = MW'(r_b);
                mul_b = MW'(r_y);
            end
            S_F0: begin
                mul_a            = MW'(r_s0);
                mul_b            = MW'(s2_val);
                div_req.start    = (r_s0 == '0);
                div_req.dividend = QW'(abs_ysum);
                div_req.divisor  = VW'(r_k);
            end
            S_F1: begin
                mul_a = MW'(r_s1);
                mul_b = MW'(r_s1);
            end
            S_F3: begin
                mul_a            = MW'(r_s2);
                mul_b            = MW'($signed(r_t0[47:16]));
                div_req.start    = (r_det == '0);
                div_req.dividend = QW'(abs_t0);
                div_req.divisor  = VW'(r_s0);
            end
            S_F4: begin
                mul_a = MW'(r_s1);
                mul_b = MW'($signed(r_t1[47:16]));
            end
            S_F5: begin
                div_req.start    = 1'b1;
                div_req.dividend = abs_num[QW-1:0];
                div_req.divisor  = abs_det;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (accept && i_last_point) n_state = S_KMUL;
            S_KMUL: n_state = S_KSET;
            S_KSET: n_state = S_RP;
            S_RP:   n_state = S_RPD;
            S_RPD:  n_state = S_RQ;
            S_RQ:   n_state = S_RQD;
            S_RQD:  n_state = q_last ? S_RW : S_RQ;
            S_RW:   n_state = p_last ? S_WRI : S_RP;
            S_WRI:  n_state = S_WDI;
            S_WDI:  n_state = S_MRD;
            S_MRD:  n_state = S_MDAT;
            S_MDAT: n_state = j_last ? S_BRD : S_MRD;
            S_BRD:  n_state = S_BDAT;
            S_BDAT: n_state = (r_maxd == '0) ? S_BWU : S_BDIV;
            S_BDIV: begin
                if (div_rsp.done) begin
                    n_state = div_rsp.quotient[16] ? S_BWU : S_BM1;
                end
            end
            S_BM1:  n_state = S_BM2;
            S_BM2:  n_state = S_BM3;
            S_BM3:  n_state = S_BM4;
            S_BM4:  n_state = S_BM5;
            S_BM5:  n_state = S_BWU;
            S_BWU:  n_state = S_BB;
            S_BB:   n_state = S_BBU;
            S_BBU:  n_state = S_BWY;
            S_BWY:  n_state = S_BBY;
            S_BBY:  n_state = j_last ? S_F0 : S_BRD;
            S_F0:   n_state = (r_s0 == '0) ? S_FDIV : S_F1;
            S_F1:   n_state = S_F2;
            S_F2:   n_state = S_F3;
            S_F3:   n_state = (r_det == '0) ? S_FDIV : S_F4;
            S_F4:   n_state = S_F5;
            S_F5:   n_state = S_FDIV;
            S_FDIV: begin
                if (div_rsp.done) begin
                    n_state = i_last ? S_ORD : S_WRI;
                end
            end
            S_ORD:  n_state = S_OLAT;
            S_OLAT: n_state = o_last ? S_IDLE : S_ORD;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_n     <= '0;
            r_span  <= lowess_pkg::ONE_Q16;
            r_ostb  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ostb  <= (r_state == S_OLAT);
            if (i_cfg_we) begin
                r_span <= i_cfg_data;
            end
            if (accept) begin
                if (i_last_point) begin
                    r_n   <= r_cnt + CW'(room);
                    r_cnt <= '0;
                end else if (room) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

    // Memories: one write port and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (x_we) begin
            r_x_store[r_cnt[IW-1:0]] <= i_x_value;
            r_y_store[r_cnt[IW-1:0]] <= i_y_value;
        end
        r_x_rd <= r_x_store[rk_addr];
        r_y_rd <= r_y_store[rk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RW) begin
            r_xs_store[r_rank] <= r_xp;
            r_ys_store[r_rank] <= r_yp;
            r_so_store[r_rank] <= r_p;
        end
        r_xs_rd <= r_xs_store[win_addr];
        r_ys_rd <= r_ys_store[win_addr];
        r_so_rd <= r_so_store[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FDIV && div_rsp.done) begin
            r_fit_store[r_soi] <= fit_sat;
        end
        r_fit_rd <= r_fit_store[r_oi];
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_KSET: begin
                r_k <= CW'(kclamp);
                r_p <= '0;
            end
            S_RPD: begin
                r_xp   <= r_x_rd;
                r_yp   <= r_y_rd;
                r_q    <= '0;
                r_rank <= '0;
            end
            S_RQD: begin
                if (rank_hit) begin
                    r_rank <= r_rank + IW'(1);
                end
                r_q <= r_q + IW'(1);
            end
            S_RW: begin
                r_p <= r_p + IW'(1);
                r_i <= '0;
            end
            S_WDI: begin
                r_xi    <= r_xs_rd;
                r_soi   <= r_so_rd;
                r_s     <= s_val;
                r_j     <= '0;
                r_maxd  <= '0;
                r_s0    <= '0;
                r_s1    <= '0;
                r_s2acc <= '0;
                r_t0    <= '0;
                r_t1    <= '0;
                r_ysum  <= '0;
            end
            S_MDAT: begin
                if (ad_val > r_maxd) begin
                    r_maxd <= ad_val;
                end
                r_j <= j_last ? '0 : r_j + IW'(1);
            end
            S_BDAT: begin
                r_dneg <= d_val[DW];
                r_y    <= r_ys_rd;
                if (r_maxd == '0) begin
                    r_ua <= '0;
                    r_w  <= lowess_pkg::ONE_Q16;
                end
            end
            S_BDIV: begin
                if (div_rsp.done) begin
                    r_ua <= div_rsp.quotient[16:0];
                    if (div_rsp.quotient[16]) begin
                        r_w <= '0;
                    end
                end
            end
            S_BM3: r_t <= t_val;
            S_BM5: r_w <= r_prod[48:32];
            S_BWU: r_u <= u_val;
            S_BB: begin
                r_b    <= b_val;
                r_s0   <= r_s0 + 24'(r_w);
                r_s1   <= r_s1 + 24'(b_val);
                r_ysum <= r_ysum + 31'(r_y);
            end
            S_BBU: r_s2acc <= r_s2acc + r_prod[39:0];
            S_BWY: r_t0 <= r_t0 + r_prod[47:0];
            S_BBY: begin
                r_t1 <= r_t1 + r_prod[47:0];
                r_j  <= r_j + IW'(1);
            end
            S_F0: begin
                r_s2   <= s2_val;
                r_qneg <= r_ysum[30];
            end
            S_F1: r_tmp <= r_prod[55:0];
            S_F2: r_det <= 32'($signed(det_diff[45:16]));
            S_F3: r_qneg <= r_t0[47];
            S_F4: r_tmp <= r_prod[55:0];
            S_F5: r_qneg <= num_val[55] ^ r_det[31];
            S_FDIV: begin
                if (div_rsp.done) begin
                    r_i  <= r_i + IW'(1);
                    r_oi <= '0;
                end
            end
            S_OLAT: begin
                r_ofit  <= r_fit_rd;
                r_oidx  <= r_oi;
                r_olast <= o_last;
                r_oi    <= r_oi + IW'(1);
            end
            default: begin
                r_b <= r_b;
            end
        endcase
    end

    lowess_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign o_strobe       = r_ostb;
    assign o_fitted_value = r_ofit;
    assign o_point_index  = r_oidx;
    assign o_last_result  = r_olast;

    // A result beat only follows the output latch state.
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_OLAT))
        else $error("result beat without output latch state");

    // Closing a set always makes the block busy on the next cycle.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last_point) |=> busy)
        else $error("set closed but block not busy");

    // The divider only finishes while the sequencer waits for it.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_BDIV || r_state == S_FDIV))
        else $error("divider finished outside a wait state");

    // Window size stays within the set once sorting starts.
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RP) |-> (r_k >= CW'(1) && r_k <= r_n))
        else $error("window size out of range");

endmodule

// File: test/tb_lowess_local_linear_fit.sv
// ----------------------------------------------------------------------------
// tb_lowess_local_linear_fit
// Self-checking bench for the one-pass local linear smoother.
// ----------------------------------------------------------------------------
// Point sets are queued by the stimulus process and sent by a clocked driver.
// The driver idles at random. Each accepted beat updates a bit-exact
// predictor. When a set closes, the predictor sorts the set, fits every
// window and queues one expected fit per point, in load order. A clocked
// monitor compares every strobed result with the oldest expected fit. The
// span register is rewritten between sets once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_lowess_local_linear_fit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [lowess_pkg::DATA_W-1:0] x;
        logic signed [lowess_pkg::DATA_W-1:0] y;
        logic                                 last;
    } t_point;

    typedef struct {
        logic signed [lowess_pkg::DATA_W-1:0] fit;
        logic [lowess_pkg::IDX_W-1:0]         idx;
        logic                                 last;
    } t_fit;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_we = 1'b0;
    logic [lowess_pkg::SPAN_W-1:0]        i_cfg_data = '0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic signed [lowess_pkg::DATA_W-1:0] i_x_value = '0;
    logic signed [lowess_pkg::DATA_W-1:0] i_y_value = '0;
    logic                                 i_last_point = 1'b0;
    logic                                 o_strobe;
    logic signed [lowess_pkg::DATA_W-1:0] o_fitted_value;
    logic [lowess_pkg::IDX_W-1:0]         o_point_index;
    logic                                 o_last_result;

    lowess_local_linear_fit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: its own copy of the span register and the point store.
    t_point       pending_points[$];
    t_fit         expected_fits[$];
    longint       span_q16 = 65536;
    longint       xs[lowess_pkg::MAX_PTS];
    longint       ys[lowess_pkg::MAX_PTS];
    int           order[lowess_pkg::MAX_PTS];
    int           loaded = 0;
    int           idle_pct = 0;
    int           mismatches = 0;
    int           stall_cycles = 0;
    t_point       drv_point;

    function automatic longint sat24(longint v);
        if (v > lowess_pkg::SAT_POS_MAG) return lowess_pkg::SAT_POS_MAG;
        if (v < -longint'(lowess_pkg::SAT_NEG_MAG)) return -longint'(lowess_pkg::SAT_NEG_MAG);
        return v;
    endfunction

    function automatic longint tricube_q16(longint ua);
        longint a, t;
        if (ua >= 65536) return 0;
        a = (ua * ua * ua) >> 32;
        t = 65536 - a;
        return (t * t * t) >> 32;
    endfunction

    // Weighted straight line over sorted window [s, s+k), evaluated at xi.
    function automatic longint window_fit(int s, int k, longint xi);
        longint maxd, d, ad, w, u, b, y;
        longint s0, s1, s2acc, t0, t1, ysum, s2, det;
        maxd = 0; s0 = 0; s1 = 0; s2acc = 0; t0 = 0; t1 = 0; ysum = 0;
        for (int j = 0; j < k; j++) begin
            d = xs[order[s + j]] - xi;
            ad = (d < 0) ? -d : d;
            if (ad > maxd) maxd = ad;
        end
        for (int j = 0; j < k; j++) begin
            d = xs[order[s + j]] - xi;
            y = ys[order[s + j]];
            if (maxd == 0) begin
                w = 65536;
                u = 0;
            end else begin
                ad = (d < 0) ? -d : d;
                ad = (ad <<< 16) / maxd;
                w = tricube_q16(ad);
                u = (d < 0) ? -ad : ad;
            end
            b = (w * u) >>> 16;
            s0 += w;
            s1 += b;
            s2acc += b * u;
            t0 += w * y;
            t1 += b * y;
            ysum += y;
        end
        // The plain mean covers a window whose weights all vanish.
        if (s0 == 0) return ysum / longint'(k);
        s2 = s2acc >>> 16;
        det = (s0 * s2 - s1 * s1) >>> 16;
        // A flat determinant falls back to the weighted mean.
        if (det == 0) return t0 / s0;
        return (s2 * (t0 >>> 16) - s1 * (t1 >>> 16)) / det;
    endfunction

    // Takes one accepted beat; a closing beat queues one fit per stored point.
    task automatic predict_beat(t_point p);
        int n, k, s, v, j;
        longint fits[lowess_pkg::MAX_PTS];
        t_fit f;
        if (loaded < lowess_pkg::MAX_PTS) begin
            xs[loaded] = p.x;
            ys[loaded] = p.y;
            loaded++;
        end
        if (!p.last) return;
        n = loaded;
        loaded = 0;
        if (n == 1) begin
            fits[0] = sat24(ys[0]);
        end else begin
            for (int i = 0; i < n; i++) order[i] = i;
            // Insertion sort keeps load order among equal x.
            for (int i = 1; i < n; i++) begin
                v = order[i];
                j = i;
                while (j > 0 && xs[order[j - 1]] > xs[v]) begin
                    order[j] = order[j - 1];
                    j--;
                end
                order[j] = v;
            end
            k = int'((span_q16 * n + 65535) >> 16);
            if (k < 2) k = 2;
            if (k > n) k = n;
            for (int i = 0; i < n; i++) begin
                s = i - k / 2;
                if (s < 0) s = 0;
                if (s > n - k) s = n - k;
                fits[order[i]] = sat24(window_fit(s, k, xs[order[i]]));
            end
        end
        for (int i = 0; i < n; i++) begin
            f.fit = fits[i][lowess_pkg::DATA_W-1:0];
            f.idx = i[lowess_pkg::IDX_W-1:0];
            f.last = (i == n - 1);
            expected_fits.insert(expected_fits.size(), f);
        end
    endtask

    // Driver: start stays high until the beat is taken; a new beat is chosen
    // only when the slot is free, so start gets one assignment per edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) predict_beat(drv_point);
            if (!start || !busy) begin
                if (pending_points.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    drv_point = pending_points.pop_front();
                    i_x_value <= drv_point.x;
                    i_y_value <= drv_point.y;
                    i_last_point <= drv_point.last;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe is one result beat and must match the oldest fit.
    always @(posedge i_clk) begin
        t_fit f;
        if (i_rst_n && o_strobe) begin
            if (expected_fits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: fit %0d idx %0d last %0d",
                             o_fitted_value, o_point_index, o_last_result);
            end else begin
                f = expected_fits.pop_front();
                if (f.fit !== o_fitted_value || f.idx !== o_point_index ||
                    f.last !== o_last_result) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch: expected fit %0d idx %0d ",
                                  "last %0d, got %0d %0d %0d"},
                                 f.fit, f.idx, f.last,
                                 o_fitted_value, o_point_index, o_last_result);
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves either way.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 300000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_point(int x, int y, bit last);
        t_point p;
        p.x = x[lowess_pkg::DATA_W-1:0];
        p.y = y[lowess_pkg::DATA_W-1:0];
        p.last = last;
        pending_points.insert(pending_points.size(), p);
    endtask

    function automatic int rand_coord(int mode);
        case (mode)
            0: return int'($urandom) >>> 8;
            1: return $urandom_range(400) - 200;
            default: return ($urandom_range(7) - 3) <<< 12;
        endcase
    endfunction

    task automatic push_random_set(int n);
        int mode, dup;
        mode = $urandom_range(2);
        dup = rand_coord(mode);
        for (int i = 0; i < n; i++)
            push_point(($urandom_range(3) == 0) ? dup : rand_coord(mode),
                       rand_coord($urandom_range(1) ? 0 : mode), i == n - 1);
    endtask

    // Quiet point: nothing queued, nothing expected, and the block settled.
    task automatic drain();
        while (pending_points.size() > 0 || expected_fits.size() > 0 || start)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_span(int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value[lowess_pkg::SPAN_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        span_q16 = value & 32'h1FFFF;
    endtask

    initial begin
        int sent;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a lone point, all x equal, extreme values at full span.
        push_point(32'h7FFFFF, -8388608, 1'b1);
        for (int i = 0; i < 5; i++) push_point(4096, i * 1000 - 2000, i == 4);
        push_point(-8388608, 8388607, 1'b0);
        push_point(8388607, -8388608, 1'b0);
        push_point(-8388608, -8388608, 1'b0);
        push_point(8388607, 8388607, 1'b1);
        drain();

        // Smallest span gives two-point windows; then the store overflows and
        // the dropped closing beat still starts fitting.
        write_span(1);
        for (int i = 0; i < 66; i++)
            push_point(rand_coord(0), rand_coord(0), i == 65);
        drain();
        write_span(0);
        push_random_set(6);
        drain();
        write_span(131071);
        push_random_set(7);
        drain();

        // Random sets in six phases over three idle settings, span rewritten between them.
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            idle_pct = (ph < 2) ? 33 : (ph < 4) ? 56 : 0;
            case (ph % 3)
                0: write_span(65536);
                1: write_span($urandom_range(65536, 1));
                default: write_span($urandom_range(131071));
            endcase
            while (sent < (ph + 1) * 28) begin
                int n;
                n = ($urandom_range(15) == 0) ? $urandom_range(24, 12)
                                              : $urandom_range(10, 1);
                push_random_set(n);
                sent += n;
                // Now and then let the sender wait for every fit to come back.
                if ($urandom_range(3) == 0) drain();
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
